[sv/vps_pkg.sv]
// Shared types, constants and step table for the vibration pattern sequencer.
`timescale 1ns / 1ps

package vps_pkg;

    // Input item
    typedef struct packed {
        logic       req_type;
        logic [1:0] pattern_id;
    } req_t;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic        motor_on;
        logic [31:0] pwm_width;
        logic        busy_res;
    } rsp_t;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_START = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BUSY        = 2'd1,
        ST_DENIED      = 2'd2,
        ST_BAD_PATTERN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PAT_CLICK  = 2'd0,
        PAT_NOTIFY = 2'd1,
        PAT_ALARM  = 2'd2,
        PAT_NONE   = 2'd3
    } pattern_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_PLAY = 1'b1
    } seq_state_t;

    // Register indexes (paddr[2])
    localparam logic REG_MOTOR_ALLOWED = 1'b0;
    localparam logic REG_PWM_PERIOD    = 1'b1;

    localparam int          PADDR_W           = 3;
    localparam logic [31:0] PWM_PERIOD_RESET  = 32'd1000000;

    // period / 100 == ((period >> 2) * PERIOD_RECIP) >> 35, exact for 32-bit periods
    localparam logic [30:0] PERIOD_RECIP = 31'd1374389535;
    localparam int          RECIP_SHIFT  = 35;
    localparam int          QUOT_W       = 26;

    localparam int DUTY_W    = 7;
    localparam int MS_W      = 9;
    localparam int STEP_W    = 5;
    localparam int ROM_USED  = 26;
    localparam int ROM_IDX_W = $clog2(ROM_USED);
    localparam int ADDR_W    = 6;

    typedef struct packed {
        logic              en;
        logic [DUTY_W-1:0] pct;
        logic [MS_W-1:0]   ms;
    } step_t;

    localparam step_t STEP_ROM [ROM_USED] = '{
        // click
        '{1'b1, 7'd90,  9'd40},  '{1'b0, 7'd0,   9'd0},
        // notification
        '{1'b1, 7'd100, 9'd50},  '{1'b0, 7'd100, 9'd50},  '{1'b1, 7'd100, 9'd50},
        '{1'b0, 7'd100, 9'd50},  '{1'b1, 7'd0,   9'd50},  '{1'b0, 7'd0,   9'd0},
        // alarm
        '{1'b1, 7'd100, 9'd200}, '{1'b0, 7'd0,   9'd100}, '{1'b1, 7'd100, 9'd200},
        '{1'b0, 7'd0,   9'd100}, '{1'b1, 7'd100, 9'd200}, '{1'b0, 7'd0,   9'd300},
        '{1'b1, 7'd100, 9'd100}, '{1'b0, 7'd0,   9'd100}, '{1'b1, 7'd100, 9'd100},
        '{1'b0, 7'd0,   9'd100}, '{1'b1, 7'd100, 9'd100}, '{1'b0, 7'd0,   9'd0},
        '{1'b1, 7'd100, 9'd100}, '{1'b0, 7'd0,   9'd100}, '{1'b1, 7'd100, 9'd100},
        '{1'b0, 7'd0,   9'd100}, '{1'b1, 7'd100, 9'd100}, '{1'b0, 7'd0,   9'd0}
    };

    function automatic logic [ADDR_W-1:0] pat_base(input logic [1:0] pid);
        logic [ADDR_W-1:0] b;
        unique case (pid)
            PAT_CLICK:  b = ADDR_W'(0);
            PAT_NOTIFY: b = ADDR_W'(2);
            PAT_ALARM:  b = ADDR_W'(8);
            default:    b = ADDR_W'(0);
        endcase
        return b;
    endfunction

    function automatic logic [ADDR_W-1:0] pat_len(input logic [1:0] pid);
        logic [ADDR_W-1:0] n;
        unique case (pid)
            PAT_CLICK:  n = ADDR_W'(2);
            PAT_NOTIFY: n = ADDR_W'(6);
            PAT_ALARM:  n = ADDR_W'(18);
            default:    n = ADDR_W'(0);
        endcase
        return n;
    endfunction

    // Addresses past the table read as an all-zero step
    function automatic step_t step_read(input logic [1:0] pid, input logic [STEP_W-1:0] idx);
        logic [ADDR_W-1:0] addr;
        step_t             s;
        addr = pat_base(pid) + ADDR_W'(idx);
        if (addr < ADDR_W'(ROM_USED))
            s = STEP_ROM[addr[ROM_IDX_W-1:0]];
        else
            s = '0;
        return s;
    endfunction

    // Sequencer outputs after one item
    typedef struct packed {
        logic [1:0]        status;
        logic              motor_on;
        logic [DUTY_W-1:0] duty;
        logic              busy;
    } seq_res_t;

endpackage

[sv/vibration_pattern_sequencer.sv]
// Top level: config registers, step sequencer and two-stage pulse width pipeline.
// An accepted item is registered in stage 1, then in stage 2, whose register presents the result.
// Throughput: one item per cycle; req_ready stays high unless both pipeline
// stages are full and the result is not taken.
// Stage 1 holds period/100 (reciprocal multiply), stage 2 scales it by duty.
// Reset: pattern idle, motor off, duty 0, motor_allowed 1, pwm_period 1000000.
`timescale 1ns / 1ps

module vibration_pattern_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vps_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  vps_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output vps_pkg::rsp_t                rsp
);
    import vps_pkg::*;

    logic               allowed_reg;
    logic [31:0]        period_reg;
    logic               cfg_wr;
    logic               accept;
    logic               adv2;
    seq_res_t           seq_res;
    logic [60:0]        recip_prod;

    logic               v1_reg;
    seq_res_t           s1_res_reg;
    logic [QUOT_W-1:0]  s1_quot_reg;
    logic [32:0]        pulse_prod;

    logic               v2_reg;
    rsp_t               rsp_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            allowed_reg <= 1'b1;
            period_reg  <= PWM_PERIOD_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MOTOR_ALLOWED: allowed_reg <= pwdata[0];
                REG_PWM_PERIOD:    period_reg  <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MOTOR_ALLOWED: prdata = {31'd0, allowed_reg};
            REG_PWM_PERIOD:    prdata = period_reg;
            default:           prdata = '0;
        endcase
    end

    // Handshake: each stage moves when the one after it has room
    assign adv2      = v1_reg && (!v2_reg || rsp_ready);
    assign req_ready = !v1_reg || adv2;
    assign accept    = req_valid && req_ready;

    vps_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (accept),
        .req           (req),
        .motor_allowed (allowed_reg),
        .res           (seq_res)
    );

    assign recip_prod = 61'(period_reg[31:2]) * 61'(PERIOD_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (accept)
            v1_reg <= 1'b1;
        else if (adv2)
            v1_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_res_reg  <= seq_res;
            s1_quot_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    assign pulse_prod = 33'(s1_quot_reg) * 33'(s1_res_reg.duty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv2)
            v2_reg <= 1'b1;
        else if (rsp_ready)
            v2_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv2) begin
            rsp_reg.status    <= s1_res_reg.status;
            rsp_reg.motor_on  <= s1_res_reg.motor_on;
            rsp_reg.pwm_width <= pulse_prod[31:0];
            rsp_reg.busy_res  <= s1_res_reg.busy;
        end
    end

    assign rsp_valid = v2_reg;
    assign rsp       = rsp_reg;

endmodule

[sv/vps_seq.sv]
// Step sequencer: pattern start checks, millisecond countdown and step loading.
`timescale 1ns / 1ps

module vps_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  vps_pkg::req_t    req,
    input  logic             motor_allowed,
    output vps_pkg::seq_res_t res
);
    import vps_pkg::*;

    seq_state_t         state_reg, state_next;
    logic [1:0]         pat_reg, pat_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [MS_W-1:0]    remain_reg, remain_next;
    logic               pin_reg, pin_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  idx_inc;
    step_t              ld;

    always_comb
    begin
        state_next  = state_reg;
        pat_next    = pat_reg;
        step_next   = step_reg;
        remain_next = remain_reg;
        pin_next    = pin_reg;
        duty_next   = duty_reg;
        status      = ST_OK;
        idx_inc     = ADDR_W'(step_reg) + ADDR_W'(1);
        ld          = '0;
        if (req.req_type == REQ_START) begin
            priority if (state_reg == SEQ_PLAY) begin
                status = ST_BUSY;
            end else if (!motor_allowed) begin
                status = ST_DENIED;
            end else if (pat_len(req.pattern_id) == '0) begin
                status = ST_BAD_PATTERN;
            end else begin
                ld          = step_read(req.pattern_id, '0);
                state_next  = SEQ_PLAY;
                pat_next    = req.pattern_id;
                step_next   = '0;
                remain_next = ld.ms;
                pin_next    = ld.en;
                duty_next   = ld.pct;
            end
        end else if (state_reg == SEQ_PLAY) begin
            priority if (remain_reg > MS_W'(1)) begin
                remain_next = remain_reg - MS_W'(1);
            end else if (idx_inc < pat_len(pat_reg)) begin
                ld          = step_read(pat_reg, idx_inc[STEP_W-1:0]);
                step_next   = idx_inc[STEP_W-1:0];
                remain_next = ld.ms;
                pin_next    = ld.en;
                duty_next   = ld.pct;
            end else begin
                // last step done: pin and duty stay as they are
                state_next  = SEQ_IDLE;
                remain_next = '0;
            end
        end
    end

    always_comb
    begin
        res.status   = status;
        res.motor_on = pin_next;
        res.duty     = duty_next;
        res.busy     = (state_next == SEQ_PLAY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= SEQ_IDLE;
            pat_reg    <= '0;
            step_reg   <= '0;
            remain_reg <= '0;
            pin_reg    <= 1'b0;
            duty_reg   <= '0;
        end else if (fire) begin
            state_reg  <= state_next;
            pat_reg    <= pat_next;
            step_reg   <= step_next;
            remain_reg <= remain_next;
            pin_reg    <= pin_next;
            duty_reg   <= duty_next;
        end
    end

endmodule

[tb/vibration_pattern_checker.sv]
// Watches the sequencer's register port and item channels, predicts each result and compares.
`timescale 1ns / 1ps

module vibration_pattern_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [vps_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  vps_pkg::req_t               req,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  vps_pkg::rsp_t               rsp,
    output int                          errors,
    output int                          pending,
    output int                          checked,
    output int                          starts_ok,
    output int                          plays_done,
    output logic                        pattern_running
);
    import vps_pkg::*;

    // register copies
    logic        allow_motor;
    logic [31:0] period;

    // sequencer state
    logic        running;
    pattern_t    cur_pattern;
    logic [4:0]  step_no;
    logic [8:0]  ms_left;
    logic        pin_on;
    logic [6:0]  duty;

    rsp_t        awaited_rsp[$];
    rsp_t        want;

    assign pattern_running = running;

    // {motor on, duty percent, duration ms}
    function automatic logic [16:0] step_entry(input int addr);
        logic [16:0] e;
        case (addr)
            0:       e = {1'b1, 7'd90,  9'd40};
            1:       e = {1'b0, 7'd0,   9'd0};
            2:       e = {1'b1, 7'd100, 9'd50};
            3:       e = {1'b0, 7'd100, 9'd50};
            4:       e = {1'b1, 7'd100, 9'd50};
            5:       e = {1'b0, 7'd100, 9'd50};
            6:       e = {1'b1, 7'd0,   9'd50};
            7:       e = {1'b0, 7'd0,   9'd0};
            8:       e = {1'b1, 7'd100, 9'd200};
            9:       e = {1'b0, 7'd0,   9'd100};
            10:      e = {1'b1, 7'd100, 9'd200};
            11:      e = {1'b0, 7'd0,   9'd100};
            12:      e = {1'b1, 7'd100, 9'd200};
            13:      e = {1'b0, 7'd0,   9'd300};
            14:      e = {1'b1, 7'd100, 9'd100};
            15:      e = {1'b0, 7'd0,   9'd100};
            16:      e = {1'b1, 7'd100, 9'd100};
            17:      e = {1'b0, 7'd0,   9'd100};
            18:      e = {1'b1, 7'd100, 9'd100};
            19:      e = {1'b0, 7'd0,   9'd0};
            20:      e = {1'b1, 7'd100, 9'd100};
            21:      e = {1'b0, 7'd0,   9'd100};
            22:      e = {1'b1, 7'd100, 9'd100};
            23:      e = {1'b0, 7'd0,   9'd100};
            24:      e = {1'b1, 7'd100, 9'd100};
            25:      e = {1'b0, 7'd0,   9'd0};
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic int pattern_base(input pattern_t p);
        int b;
        case (p)
            PAT_NOTIFY: b = 2;
            PAT_ALARM:  b = 8;
            default:    b = 0;
        endcase
        return b;
    endfunction

    function automatic int pattern_steps(input pattern_t p);
        int n;
        case (p)
            PAT_CLICK:  n = 2;
            PAT_NOTIFY: n = 6;
            PAT_ALARM:  n = 18;
            default:    n = 0;
        endcase
        return n;
    endfunction

    function automatic void enter_step();
        logic [16:0] e;
        e       = step_entry(pattern_base(cur_pattern) + int'(step_no));
        pin_on  = e[16];
        duty    = e[15:9];
        ms_left = e[8:0];
    endfunction

    // advances the sequencer by one item and returns the result it should produce
    function automatic rsp_t motor_after_item(input req_t r);
        rsp_t        res;
        logic [63:0] width;
        res.status = ST_OK;
        if (r.req_type == REQ_START)
        begin
            if (running)
                res.status = ST_BUSY;
            else if (!allow_motor)
                res.status = ST_DENIED;
            else if (r.pattern_id == PAT_NONE)
                res.status = ST_BAD_PATTERN;
            else
            begin
                cur_pattern = pattern_t'(r.pattern_id);
                step_no     = '0;
                running     = 1'b1;
                starts_ok++;
                enter_step();
            end
        end
        else if (running)
        begin
            // 0 or 1 ms left: step expires on this tick
            if (ms_left > 9'd1)
                ms_left = ms_left - 9'd1;
            else if (int'(step_no) + 1 < pattern_steps(cur_pattern))
            begin
                step_no = step_no + 5'd1;
                enter_step();
            end
            else
            begin
                // last step's pin and duty stay
                running = 1'b0;
                ms_left = '0;
                plays_done++;
            end
        end
        width         = 64'(period / 32'd100) * 64'(duty);
        res.motor_on  = pin_on;
        res.pwm_width = width[31:0];
        res.busy_res  = running;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        errors++;
        $display("[%0t] %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_motor = 1'b1;
            period      = 32'd1000000;
            running     = 1'b0;
            cur_pattern = PAT_CLICK;
            step_no     = '0;
            ms_left     = '0;
            pin_on      = 1'b0;
            duty        = '0;
            awaited_rsp.delete();
            errors      = 0;
            pending     = 0;
            checked     = 0;
            starts_ok   = 0;
            plays_done  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_MOTOR_ALLOWED: allow_motor = pwdata[0];
                    REG_PWM_PERIOD:    period      = pwdata;
                endcase
            end
            if (req_valid && req_ready)
                awaited_rsp.push_back(motor_after_item(req));
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                    report_mismatch("result with nothing pending", 0, 1);
                else
                begin
                    want = awaited_rsp.pop_front();
                    checked++;
                    if (rsp.status !== want.status)
                        report_mismatch("status", want.status, rsp.status);
                    if (rsp.motor_on !== want.motor_on)
                        report_mismatch("motor_on", want.motor_on, rsp.motor_on);
                    if (rsp.pwm_width !== want.pwm_width)
                        report_mismatch("pwm_width", want.pwm_width, rsp.pwm_width);
                    if (rsp.busy_res !== want.busy_res)
                        report_mismatch("busy_res", want.busy_res, rsp.busy_res);
                end
            end
            pending = awaited_rsp.size();
        end
    end

endmodule

[tb/vibration_pattern_sequencer_tb.sv]
// Top of the sequencer regression: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module vibration_pattern_sequencer_tb;
    import vps_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_GAP        = 4;
    localparam int RANDOM_PER_PHASE = 130;
    localparam int HOLD_CYCLES      = 80;
    // enough ticks to play out a click; longer patterns are left running
    localparam int FINISH_TICKS     = 64;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_t               rsp;

    int   errors;
    int   pending;
    int   checked;
    int   starts_ok;
    int   plays_done;
    logic pattern_running;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int sent          = 0;
    int cfg_writes    = 0;
    int cycle_count   = 0;

    vibration_pattern_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    vibration_pattern_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .errors          (errors),
        .pending         (pending),
        .checked         (checked),
        .starts_ok       (starts_ok),
        .plays_done      (plays_done),
        .pattern_running (pattern_running)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off each time one is requested
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ready = 1'b0;
                hold_left--;
            end
            else
                rsp_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // all tasks start and end at a falling edge
    task automatic send_item(input req_kind_t kind, input logic [1:0] pid);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid      = 1'b1;
        req.req_type   = kind;
        req.pattern_id = pid;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_noise_tick();
        send_item(REQ_TICK, 2'($urandom_range(3)));
    endtask

    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        cfg_writes++;
    endtask

    task automatic reconfigure(input bit motor_on_forced);
        logic [31:0] word;
        int          pick;
        wait_drained();
        word    = $urandom();
        word[0] = motor_on_forced || ($urandom_range(5) != 0);
        write_reg(REG_MOTOR_ALLOWED, word);
        pick = $urandom_range(9);
        case (pick)
            0:       word = 32'd100;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'd99;
            3, 4:    word = 32'd1000000;
            default:
            begin
                word = $urandom();
                if (word < 32'd100)
                    word = 32'd100;
            end
        endcase
        write_reg(REG_PWM_PERIOD, word);
    endtask

    task automatic finish_pattern(input int max_ticks);
        int n;
        n = 0;
        while (pattern_running && n < max_ticks)
        begin
            send_noise_tick();
            n++;
        end
    endtask

    // a start followed by ticks, with stray starts mixed in
    task automatic run_session();
        int         pick;
        int         n_ticks;
        logic [1:0] pid;
        pick = $urandom_range(99);
        if (pick < 45)
            pid = PAT_CLICK;
        else if (pick < 75)
            pid = PAT_NOTIFY;
        else if (pick < 88)
            pid = PAT_ALARM;
        else
            pid = PAT_NONE;
        if ($urandom_range(3) == 0)
            send_noise_tick();
        send_item(REQ_START, pid);
        n_ticks = $urandom_range((pid == PAT_ALARM) ? 150 : 30, 1);
        repeat (n_ticks)
        begin
            if ($urandom_range(11) == 0)
                send_item(REQ_START, 2'($urandom_range(3)));
            else
                send_noise_tick();
        end
        if (pid != PAT_ALARM && $urandom_range(1) == 0)
            finish_pattern(FINISH_TICKS);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input bit deep);
        int start_count;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        reconfigure(1'b1);
        if (deep)
        begin
            finish_pattern(FINISH_TICKS);
            send_item(REQ_START, PAT_CLICK);
            hold_requests++;
            repeat (30) send_noise_tick();
            finish_pattern(FINISH_TICKS);
            send_item(REQ_START, PAT_ALARM);
        end
        start_count = sent;
        while (sent - start_count < RANDOM_PER_PHASE)
        begin
            if ($urandom_range(3) == 0)
                reconfigure(1'b0);
            run_session();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // motor disabled: refusal wins over a bad pattern number
        write_reg(REG_MOTOR_ALLOWED, 32'd0);
        send_item(REQ_TICK, PAT_NONE);
        send_item(REQ_START, PAT_CLICK);
        send_item(REQ_START, PAT_NONE);
        wait_drained();
        write_reg(REG_MOTOR_ALLOWED, 32'd1);
        write_reg(REG_PWM_PERIOD, 32'd99);
        send_item(REQ_START, PAT_NONE);
        send_item(REQ_START, PAT_CLICK);
        send_item(REQ_START, PAT_ALARM);
        send_item(REQ_START, PAT_NONE);
        send_item(REQ_TICK, PAT_ALARM);
        wait_drained();
        write_reg(REG_PWM_PERIOD, 32'd100);
        send_item(REQ_TICK, PAT_CLICK);
        wait_drained();
        write_reg(REG_PWM_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_MOTOR_ALLOWED, 32'd0);
        // busy is reported ahead of the disabled motor
        send_item(REQ_START, PAT_NOTIFY);
        // click runs through its zero-length step to the end
        finish_pattern(FINISH_TICKS);
        send_item(REQ_TICK, PAT_NONE);
        send_item(REQ_START, PAT_CLICK);

        run_phase(19, 64, 1'b0);
        run_phase(64, 19, 1'b0);
        run_phase(0, 0, 1'b1);
        wait_drained();

        $display("Checked %0d results over %0d items: %0d patterns started, %0d played out.",
                 checked, sent, starts_ok, plays_done);
        $display("Register writes: %0d; idle mixes on both sides and one long result hold-off.",
                 cfg_writes);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/vps_pkg.sv
sv/vps_seq.sv
sv/vibration_pattern_sequencer.sv
tb/vibration_pattern_checker.sv
tb/vibration_pattern_sequencer_tb.sv
